>>> hw/rtl/ipwc_pkg.sv
package ipwc_pkg;

	// default structural parameters
	localparam int CHANNELS_DEF      = 4;
	localparam int TIMER_BITS_DEF    = 16;
	localparam int MAX_OVERFLOWS_DEF = 63;

	// field widths fixed by the interface
	localparam int NCLASS    = 3;
	localparam int CMD_W     = 2;
	localparam int CH_W      = 2;
	localparam int TIME_W    = 16;
	localparam int FLAG_W    = 12;
	localparam int WID_W     = 22;
	localparam int CLS_W     = 2;
	localparam int HR_W      = 10;
	localparam int NOM_W     = 16;
	localparam int QUAL_W    = 8;
	localparam int HOLD_W    = 7;
	localparam int RUN_W     = 8;
	localparam int REG_IDX_W = 3;
	localparam int REG_DAT_W = 16;

	// saturation limits
	localparam logic [WID_W-1:0]  WIDTH_MAX = {WID_W{1'b1}};
	localparam logic [RUN_W-1:0]  RUN_MAX   = {RUN_W{1'b1}};
	localparam logic [HOLD_W-1:0] HOLD_MAX  = {HOLD_W{1'b1}};

	// register reset values
	localparam logic [HR_W-1:0]   HALF_RANGE_RST = HR_W'(100);
	localparam logic [NOM_W-1:0]  SHORT_RST      = NOM_W'(500);
	localparam logic [NOM_W-1:0]  MIDDLE_RST     = NOM_W'(1000);
	localparam logic [NOM_W-1:0]  LONG_RST       = NOM_W'(1500);
	localparam logic [QUAL_W-1:0] QUALIFY_RST    = QUAL_W'(3);
	localparam logic [HOLD_W-1:0] HOLD_RST       = HOLD_W'(80);

	// class code when no window matched
	localparam logic [CLS_W-1:0] CLS_NONE = CLS_W'(3);

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK = 2'd0,
		CMD_CAP  = 2'd1,
		CMD_OVF  = 2'd2
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_HALF_RANGE = 3'd0,
		REG_SHORT      = 3'd1,
		REG_MIDDLE     = 3'd2,
		REG_LONG       = 3'd3,
		REG_QUALIFY    = 3'd4,
		REG_HOLD       = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [HR_W-1:0]               half_range;
		logic [NCLASS-1:0][NOM_W-1:0]  nominal;
		logic [QUAL_W-1:0]             qualify;
		logic [HOLD_W-1:0]             hold;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [CH_W-1:0]   channel;
		logic [TIME_W-1:0] edge_time;
	} req_t;

	typedef struct packed {
		logic [FLAG_W-1:0] presence_flags;
		logic              width_valid;
		logic [CH_W-1:0]   width_channel;
		logic [WID_W-1:0]  measured_width;
		logic [CLS_W-1:0]  matched_class;
	} rsp_t;

	// per-channel command decoded from the staged word
	typedef struct packed {
		logic              tick;
		logic              cap;
		logic              ovf;
		logic [TIME_W-1:0] edge_time;
	} lane_op_t;

	// per-channel outcome of the staged word
	typedef struct packed {
		logic              done;
		logic [WID_W-1:0]  width;
		logic [CLS_W-1:0]  cls;
		logic [NCLASS-1:0] flags;
	} lane_res_t;

endpackage

>>> hw/rtl/ipwc_if.sv
interface ipwc_req_if;
	logic                         valid;
	logic                         ready;
	logic [ipwc_pkg::CMD_W-1:0]   cmd;
	logic [ipwc_pkg::CH_W-1:0]    channel;
	logic [ipwc_pkg::TIME_W-1:0]  edge_time;

	modport source(output valid, cmd, channel, edge_time, input ready);
	modport sink(input valid, cmd, channel, edge_time, output ready);
endinterface

interface ipwc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ipwc_pkg::FLAG_W-1:0]  presence_flags;
	logic                         width_valid;
	logic [ipwc_pkg::CH_W-1:0]    width_channel;
	logic [ipwc_pkg::WID_W-1:0]   measured_width;
	logic [ipwc_pkg::CLS_W-1:0]   matched_class;

	modport source(output valid, presence_flags, width_valid, width_channel,
		measured_width, matched_class, input ready);
	modport sink(input valid, presence_flags, width_valid, width_channel,
		measured_width, matched_class, output ready);
endinterface

interface ipwc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ipwc_pkg::REG_IDX_W-1:0]  index;
	logic [ipwc_pkg::REG_DAT_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/ir_pulse_width_classifier.sv
// Infrared pulse-width classifier for up to CHANNELS receiver channels sharing one
// free-running TIMER_BITS counter. Each request word is a 1 ms tick, a capture edge
// on one channel, or a counter overflow; every word yields exactly one response
// word carrying the presence flags after that word and, when a measurement ended,
// its channel, width and class (the lowest channel when one overflow ends several).
// A word is held in an input register and resolved in one pass through per-channel
// lanes into a response register, so one word is taken per clock cycle while the
// response side does not stall.
// The user must write registers only while no word is in flight; the block does not enforce it.
module ir_pulse_width_classifier #(
	parameter int CHANNELS      = ipwc_pkg::CHANNELS_DEF,
	parameter int TIMER_BITS    = ipwc_pkg::TIMER_BITS_DEF,
	parameter int MAX_OVERFLOWS = ipwc_pkg::MAX_OVERFLOWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ipwc_req_if.sink    req,
	ipwc_rsp_if.source  rsp,
	ipwc_cfg_if.sink    cfg
);

	localparam int NC = ipwc_pkg::NCLASS;

	ipwc_pkg::cfg_t                     regs;
	ipwc_pkg::req_t                     req_s1;
	logic                               vld_s1;
	ipwc_pkg::rsp_t                     rsp_q, rsp_d;
	logic                               rsp_vld_q;
	logic                               adv;
	ipwc_pkg::lane_op_t [CHANNELS-1:0]  op;
	ipwc_pkg::lane_res_t [CHANNELS-1:0] res;

	// handshake: the staged word moves when the response register is free
	assign adv       = vld_s1 && (!rsp_vld_q || rsp.ready);
	assign req.ready = !vld_s1 || adv;

	ipwc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.cmd       <= req.cmd;
			req_s1.channel   <= req.channel;
			req_s1.edge_time <= req.edge_time;
		end
	end

	// command decode per channel
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			op[c] = '0;
			op[c].edge_time = req_s1.edge_time;
			case (ipwc_pkg::cmd_t'(req_s1.cmd))
				ipwc_pkg::CMD_TICK: op[c].tick = 1'b1;
				ipwc_pkg::CMD_CAP:  op[c].cap  = (int'(req_s1.channel) == c);
				ipwc_pkg::CMD_OVF:  op[c].ovf  = 1'b1;
				default: ;
			endcase
		end
	end

	// one lane per channel
	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		ipwc_lane #(
			.TIMER_BITS    (TIMER_BITS),
			.MAX_OVERFLOWS (MAX_OVERFLOWS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.op     (op[g]),
			.cfg    (regs),
			.res    (res[g])
		);
	end

	// merge lanes: flags and lowest finished channel
	always_comb begin
		rsp_d = '0;
		for (int c = CHANNELS - 1; c >= 0; c--) begin
			if (res[c].done) begin
				rsp_d.width_valid    = 1'b1;
				rsp_d.width_channel  = ipwc_pkg::CH_W'(c);
				rsp_d.measured_width = res[c].width;
				rsp_d.matched_class  = res[c].cls;
			end
		end
		for (int c = 0; c < CHANNELS; c++) begin
			for (int k = 0; k < NC; k++) begin
				if (c * NC + k < ipwc_pkg::FLAG_W)
					rsp_d.presence_flags[c * NC + k] = res[c].flags[k];
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (adv) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			rsp_q <= rsp_d;
	end

	assign rsp.valid          = rsp_vld_q;
	assign rsp.presence_flags = rsp_q.presence_flags;
	assign rsp.width_valid    = rsp_q.width_valid;
	assign rsp.width_channel  = rsp_q.width_channel;
	assign rsp.measured_width = rsp_q.measured_width;
	assign rsp.matched_class  = rsp_q.matched_class;

	// no measurement means zero width fields
	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.width_valid |->
			rsp.measured_width == '0 && rsp.matched_class == '0 && rsp.width_channel == '0)
		else $error("width fields set without a finished measurement");

	// a matched class has a width no larger than the top of the widest possible window
	a_class_width: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.width_valid && rsp.matched_class != ipwc_pkg::CLS_NONE |->
			rsp.measured_width <= ipwc_pkg::WID_W'((1 << ipwc_pkg::NOM_W) + (1 << ipwc_pkg::HR_W)))
		else $error("matched class with a width outside every window");

	// reported channel exists
	a_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.width_valid |-> int'(rsp.width_channel) < CHANNELS)
		else $error("measurement reported on a missing channel");

	// a staged word waits while the response side is full
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(req_s1))
		else $error("staged word lost while stalled");

endmodule

>>> hw/rtl/ipwc_cfg.sv
module ipwc_cfg (
	input  logic            clk,
	input  logic            arst_n,
	ipwc_cfg_if.sink        cfg,
	output ipwc_pkg::cfg_t  regs
);

	ipwc_pkg::cfg_t regs_q;

	// writes are always taken
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.half_range <= ipwc_pkg::HALF_RANGE_RST;
			regs_q.nominal[0] <= ipwc_pkg::SHORT_RST;
			regs_q.nominal[1] <= ipwc_pkg::MIDDLE_RST;
			regs_q.nominal[2] <= ipwc_pkg::LONG_RST;
			regs_q.qualify    <= ipwc_pkg::QUALIFY_RST;
			regs_q.hold       <= ipwc_pkg::HOLD_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (ipwc_pkg::reg_idx_t'(cfg.index))
				ipwc_pkg::REG_HALF_RANGE: regs_q.half_range <= cfg.data[ipwc_pkg::HR_W-1:0];
				ipwc_pkg::REG_SHORT:      regs_q.nominal[0] <= cfg.data[ipwc_pkg::NOM_W-1:0];
				ipwc_pkg::REG_MIDDLE:     regs_q.nominal[1] <= cfg.data[ipwc_pkg::NOM_W-1:0];
				ipwc_pkg::REG_LONG:       regs_q.nominal[2] <= cfg.data[ipwc_pkg::NOM_W-1:0];
				ipwc_pkg::REG_QUALIFY:    regs_q.qualify    <= cfg.data[ipwc_pkg::QUAL_W-1:0];
				ipwc_pkg::REG_HOLD:       regs_q.hold       <= cfg.data[ipwc_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/ipwc_lane.sv
module ipwc_lane #(
	parameter int TIMER_BITS    = ipwc_pkg::TIMER_BITS_DEF,
	parameter int MAX_OVERFLOWS = ipwc_pkg::MAX_OVERFLOWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  ipwc_pkg::lane_op_t   op,
	input  ipwc_pkg::cfg_t       cfg,
	output ipwc_pkg::lane_res_t  res
);

	localparam int OVF_W = $clog2(MAX_OVERFLOWS + 1);
	localparam int ET_W  = (TIMER_BITS < ipwc_pkg::TIME_W) ? TIMER_BITS : ipwc_pkg::TIME_W;
	localparam int TOT_W = OVF_W + TIMER_BITS;
	localparam int CMP_W = (TOT_W > ipwc_pkg::WID_W) ? TOT_W : ipwc_pkg::WID_W;
	localparam int NC    = ipwc_pkg::NCLASS;

	// channel state
	logic                                  armed_q, armed_d;
	logic [OVF_W-1:0]                      ovf_q, ovf_d;
	logic [ET_W-1:0]                       start_q, start_d;
	logic [NC-1:0][ipwc_pkg::RUN_W-1:0]    run_q, run_d;
	logic [NC-1:0]                         flag_q, flag_d;
	logic [NC-1:0][ipwc_pkg::HOLD_W-1:0]   hold_q, hold_d;

	// measurement path
	logic                                  fin;
	logic [TIMER_BITS-1:0]                 end_tb;
	logic [TOT_W-1:0]                      total;
	logic [TOT_W-1:0]                      diff;
	logic                                  neg;
	logic [ipwc_pkg::WID_W-1:0]            wid;
	logic [ipwc_pkg::WID_W:0]              wid_hi;
	logic [ipwc_pkg::NOM_W:0]              nom_hi;
	logic [NC-1:0]                         win;
	logic [NC-1:0]                         sel;
	logic                                  found;
	logic [ipwc_pkg::CLS_W-1:0]            cls;
	logic [ipwc_pkg::RUN_W-1:0]            run_inc;

	// width and window match
	always_comb begin
		total = {ovf_q, end_tb};
		neg   = total < TOT_W'(start_q);
		diff  = total - TOT_W'(start_q);
		if (neg || (CMP_W'(diff) > CMP_W'(ipwc_pkg::WIDTH_MAX)))
			wid = ipwc_pkg::WIDTH_MAX;
		else
			wid = ipwc_pkg::WID_W'(diff);
		found = 1'b0;
		cls   = ipwc_pkg::CLS_NONE;
		for (int k = 0; k < NC; k++) begin
			wid_hi = {1'b0, wid} + (ipwc_pkg::WID_W + 1)'(cfg.half_range);
			nom_hi = {1'b0, cfg.nominal[k]} + (ipwc_pkg::NOM_W + 1)'(cfg.half_range);
			win[k] = !neg && (wid_hi >= (ipwc_pkg::WID_W + 1)'(cfg.nominal[k]))
				&& ({1'b0, wid} <= (ipwc_pkg::WID_W + 1)'(nom_hi));
			sel[k] = win[k] && !found;
			if (sel[k]) begin
				cls   = ipwc_pkg::CLS_W'(k);
				found = 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		armed_d = armed_q;
		ovf_d   = ovf_q;
		start_d = start_q;
		run_d   = run_q;
		flag_d  = flag_q;
		hold_d  = hold_q;
		fin     = 1'b0;
		end_tb  = TIMER_BITS'(op.edge_time);
		run_inc = '0;
		if (op.cap) begin
			if (armed_q) begin
				fin = 1'b1;
			end else begin
				armed_d = 1'b1;
				ovf_d   = '0;
				start_d = ET_W'(op.edge_time);
			end
		end
		if (op.ovf && armed_q) begin
			if (ovf_q >= OVF_W'(MAX_OVERFLOWS)) begin
				fin    = 1'b1;
				end_tb = '1;
			end else begin
				ovf_d = ovf_q + 1'b1;
			end
		end
		// hold aging on the millisecond tick
		if (op.tick) begin
			for (int k = 0; k < NC; k++) begin
				if (hold_q[k] <= cfg.hold) begin
					if (hold_q[k] != ipwc_pkg::HOLD_MAX)
						hold_d[k] = hold_q[k] + 1'b1;
				end else begin
					flag_d[k] = 1'b0;
				end
			end
		end
		// finished measurement updates run counters
		if (fin) begin
			armed_d = 1'b0;
			ovf_d   = '0;
			for (int k = 0; k < NC; k++) begin
				if (sel[k]) begin
					run_inc  = (run_q[k] != ipwc_pkg::RUN_MAX) ? run_q[k] + 1'b1 : run_q[k];
					run_d[k] = run_inc;
					if (run_inc >= cfg.qualify) begin
						flag_d[k] = 1'b1;
						hold_d[k] = '0;
					end
				end else if (found) begin
					run_d[k] = '0;
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			ovf_q   <= '0;
			start_q <= '0;
			run_q   <= '0;
			flag_q  <= '0;
			hold_q  <= '0;
		end else if (adv) begin
			armed_q <= armed_d;
			ovf_q   <= ovf_d;
			start_q <= start_d;
			run_q   <= run_d;
			flag_q  <= flag_d;
			hold_q  <= hold_d;
		end
	end

	assign res.done  = fin;
	assign res.width = wid;
	assign res.cls   = cls;
	assign res.flags = flag_d;

endmodule

>>> tb/ir_pulse_width_classifier_tb.sv
`timescale 1ns / 100ps

module ir_pulse_width_classifier_tb;

	localparam int CHANNELS     = ipwc_pkg::CHANNELS_DEF;
	localparam int MAX_OVF      = ipwc_pkg::MAX_OVERFLOWS_DEF;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int STALL_CYCLES = 300;
	localparam int N_ROWS       = 22;
	localparam logic [ipwc_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	// one directed stimulus row, optionally with a hand-written expected word
	typedef struct packed {
		logic [ipwc_pkg::CMD_W-1:0]  cmd;
		logic [ipwc_pkg::CH_W-1:0]   channel;
		logic [ipwc_pkg::TIME_W-1:0] edge_time;
		logic [7:0]                  reps;
		logic                        typed;
		ipwc_pkg::rsp_t              want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	ipwc_req_if req_bus ();
	ipwc_rsp_if rsp_bus ();
	ipwc_cfg_if cfg_bus ();

	ir_pulse_width_classifier dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted configuration and per-channel measurement state
	ipwc_pkg::cfg_t                  cfg_model;
	logic                            armed_q  [CHANNELS];
	logic [5:0]                      ovf_cnt  [CHANNELS];
	logic [ipwc_pkg::TIME_W-1:0]     start_q  [CHANNELS];
	logic [ipwc_pkg::RUN_W-1:0]      run_cnt  [CHANNELS][ipwc_pkg::NCLASS];
	logic                            flag_q   [CHANNELS][ipwc_pkg::NCLASS];
	logic [ipwc_pkg::HOLD_W-1:0]     hold_cnt [CHANNELS][ipwc_pkg::NCLASS];

	ipwc_pkg::rsp_t expected_words [$];
	int   mismatch_count = 0;
	int   idle_cycles = 0;
	int   send_idle_max = 16;
	int   recv_idle_max = 16;
	bit   stall_req = 1'b0;

	// directed rows, checked against typed words where the value is obvious
	dir_row_t dir_rows [N_ROWS] = '{
		// after reset, then an unknown command with every bit high
		'{ipwc_pkg::CMD_TICK, 2'd0, 16'h0000, 8'd1, 1'b1, '{12'h000, 1'b0, 2'd0, 22'd0, 2'd0}},
		'{CMD_UNKNOWN, 2'd3, 16'hFFFF, 8'd1, 1'b1, '{12'h000, 1'b0, 2'd0, 22'd0, 2'd0}},
		// three nominal short pulses qualify the short class on channel 0
		'{ipwc_pkg::CMD_CAP, 2'd0, 16'd0, 8'd1, 1'b1, '{12'h000, 1'b0, 2'd0, 22'd0, 2'd0}},
		'{ipwc_pkg::CMD_CAP, 2'd0, 16'd500, 8'd1, 1'b1, '{12'h000, 1'b1, 2'd0, 22'd500, 2'd0}},
		'{ipwc_pkg::CMD_CAP, 2'd0, 16'd1000, 8'd1, 1'b0, '0},
		'{ipwc_pkg::CMD_CAP, 2'd0, 16'd1500, 8'd1, 1'b1, '{12'h000, 1'b1, 2'd0, 22'd500, 2'd0}},
		'{ipwc_pkg::CMD_CAP, 2'd0, 16'd2000, 8'd1, 1'b0, '0},
		'{ipwc_pkg::CMD_CAP, 2'd0, 16'd2500, 8'd1, 1'b1, '{12'h001, 1'b1, 2'd0, 22'd500, 2'd0}},
		// end before start without overflow
		'{ipwc_pkg::CMD_CAP, 2'd1, 16'hFFFF, 8'd1, 1'b0, '0},
		'{ipwc_pkg::CMD_CAP, 2'd1, 16'd0, 8'd1, 1'b1,
			'{12'h001, 1'b1, 2'd1, ipwc_pkg::WIDTH_MAX, ipwc_pkg::CLS_NONE}},
		// window edges: low short edge, high long edge, just past it
		'{ipwc_pkg::CMD_CAP, 2'd1, 16'd0, 8'd1, 1'b0, '0},
		'{ipwc_pkg::CMD_CAP, 2'd1, 16'd400, 8'd1, 1'b1, '{12'h001, 1'b1, 2'd1, 22'd400, 2'd0}},
		'{ipwc_pkg::CMD_CAP, 2'd1, 16'd1000, 8'd1, 1'b0, '0},
		'{ipwc_pkg::CMD_CAP, 2'd1, 16'd2600, 8'd1, 1'b1, '{12'h001, 1'b1, 2'd1, 22'd1600, 2'd2}},
		'{ipwc_pkg::CMD_CAP, 2'd1, 16'd0, 8'd1, 1'b0, '0},
		'{ipwc_pkg::CMD_CAP, 2'd1, 16'd1601, 8'd1, 1'b1,
			'{12'h001, 1'b1, 2'd1, 22'd1601, ipwc_pkg::CLS_NONE}},
		// two channels run out of overflows together, lowest one reported
		'{ipwc_pkg::CMD_CAP, 2'd2, 16'd0, 8'd1, 1'b0, '0},
		'{ipwc_pkg::CMD_CAP, 2'd3, 16'hFFFF, 8'd1, 1'b0, '0},
		'{ipwc_pkg::CMD_OVF, 2'd0, 16'd0, 8'd64, 1'b1,
			'{12'h001, 1'b1, 2'd2, ipwc_pkg::WIDTH_MAX, ipwc_pkg::CLS_NONE}},
		'{ipwc_pkg::CMD_OVF, 2'd2, 16'h5A5A, 8'd1, 1'b0, '0},
		// flag ages out after the hold time, then further ticks leave it cleared
		'{ipwc_pkg::CMD_TICK, 2'd0, 16'd0, 8'd82, 1'b1, '{12'h000, 1'b0, 2'd0, 22'd0, 2'd0}},
		'{ipwc_pkg::CMD_TICK, 2'd1, 16'hA5A5, 8'd50, 1'b0, '0}
	};

	// close a measurement on one channel and classify its width
	function automatic logic [ipwc_pkg::WID_W-1:0] end_measure(input int ch,
		input logic [ipwc_pkg::TIME_W-1:0] end_t, output logic [ipwc_pkg::CLS_W-1:0] cls);
		longint total, w, lo, hi;
		cls = ipwc_pkg::CLS_NONE;
		total = (longint'(ovf_cnt[ch]) << ipwc_pkg::TIME_W) + longint'(end_t);
		armed_q[ch] = 1'b0;
		ovf_cnt[ch] = '0;
		if (total < longint'(start_q[ch]))
			return ipwc_pkg::WIDTH_MAX;
		w = total - longint'(start_q[ch]);
		if (w > longint'(ipwc_pkg::WIDTH_MAX))
			w = longint'(ipwc_pkg::WIDTH_MAX);
		for (int k = 0; k < ipwc_pkg::NCLASS; k++) begin
			lo = longint'(cfg_model.nominal[k]) - longint'(cfg_model.half_range);
			hi = longint'(cfg_model.nominal[k]) + longint'(cfg_model.half_range);
			if (w >= lo && w <= hi) begin
				for (int j = 0; j < ipwc_pkg::NCLASS; j++)
					if (j != k)
						run_cnt[ch][j] = '0;
				if (run_cnt[ch][k] != ipwc_pkg::RUN_MAX)
					run_cnt[ch][k] = run_cnt[ch][k] + 1'b1;
				if (run_cnt[ch][k] >= cfg_model.qualify) begin
					flag_q[ch][k]   = 1'b1;
					hold_cnt[ch][k] = '0;
				end
				cls = ipwc_pkg::CLS_W'(k);
				break;
			end
		end
		return ipwc_pkg::WID_W'(w);
	endfunction

	// advance the predicted state by one word and build the expected response
	function automatic ipwc_pkg::rsp_t classify_word(input logic [ipwc_pkg::CMD_W-1:0] cmd,
		input logic [ipwc_pkg::CH_W-1:0] ch, input logic [ipwc_pkg::TIME_W-1:0] et);
		ipwc_pkg::rsp_t res;
		logic [ipwc_pkg::WID_W-1:0] w;
		logic [ipwc_pkg::CLS_W-1:0] cls;
		res = '0;
		case (cmd)
			ipwc_pkg::CMD_TICK: begin
				for (int c = 0; c < CHANNELS; c++)
					for (int k = 0; k < ipwc_pkg::NCLASS; k++)
						if (hold_cnt[c][k] <= cfg_model.hold) begin
							if (hold_cnt[c][k] != ipwc_pkg::HOLD_MAX)
								hold_cnt[c][k] = hold_cnt[c][k] + 1'b1;
						end else begin
							flag_q[c][k] = 1'b0;
						end
			end
			ipwc_pkg::CMD_CAP: begin
				if (int'(ch) < CHANNELS) begin
					if (armed_q[ch]) begin
						res.measured_width = end_measure(int'(ch), et, cls);
						res.matched_class  = cls;
						res.width_valid    = 1'b1;
						res.width_channel  = ch;
					end else begin
						armed_q[ch] = 1'b1;
						ovf_cnt[ch] = '0;
						start_q[ch] = et;
					end
				end
			end
			ipwc_pkg::CMD_OVF: begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (!armed_q[c])
						continue;
					if (int'(ovf_cnt[c]) >= MAX_OVF) begin
						w = end_measure(c, '1, cls);
						if (!res.width_valid) begin
							res.width_valid    = 1'b1;
							res.width_channel  = ipwc_pkg::CH_W'(c);
							res.measured_width = w;
							res.matched_class  = cls;
						end
					end else begin
						ovf_cnt[c] = ovf_cnt[c] + 1'b1;
					end
				end
			end
			default: ;
		endcase
		for (int c = 0; c < CHANNELS; c++)
			for (int k = 0; k < ipwc_pkg::NCLASS; k++)
				res.presence_flags[c * ipwc_pkg::NCLASS + k] = flag_q[c][k];
		return res;
	endfunction

	task automatic note_mismatch(input string field, input logic [31:0] want,
		input logic [31:0] got);
		$display("%0t ns: %s expected 0x%0h got 0x%0h", $time, field, want, got);
		mismatch_count++;
	endtask

	// offer one word after a random gap, predict it once accepted
	task automatic send_word(input logic [ipwc_pkg::CMD_W-1:0] cmd,
		input logic [ipwc_pkg::CH_W-1:0] ch, input logic [ipwc_pkg::TIME_W-1:0] et,
		input logic typed, input ipwc_pkg::rsp_t want);
		int gap;
		ipwc_pkg::rsp_t model_word;
		gap = $urandom_range(0, send_idle_max);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid     <= 1'b1;
		req_bus.cmd       <= cmd;
		req_bus.channel   <= ch;
		req_bus.edge_time <= et;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		model_word = classify_word(cmd, ch, et);
		expected_words.push_back(typed ? want : model_word);
	endtask

	// write all six registers, only while nothing is in flight
	task automatic write_settings(input logic [ipwc_pkg::HR_W-1:0] half,
		input logic [ipwc_pkg::NOM_W-1:0] s_nom, input logic [ipwc_pkg::NOM_W-1:0] m_nom,
		input logic [ipwc_pkg::NOM_W-1:0] l_nom, input logic [ipwc_pkg::QUAL_W-1:0] qual,
		input logic [ipwc_pkg::HOLD_W-1:0] hold);
		logic [ipwc_pkg::REG_DAT_W-1:0] vals [6];
		ipwc_pkg::reg_idx_t idx;
		vals = '{ipwc_pkg::REG_DAT_W'(half), s_nom, m_nom, l_nom,
			ipwc_pkg::REG_DAT_W'(qual), ipwc_pkg::REG_DAT_W'(hold)};
		for (int i = 0; i < 6; i++) begin
			idx = ipwc_pkg::reg_idx_t'(i);
			cfg_bus.valid <= 1'b1;
			cfg_bus.index <= idx;
			cfg_bus.data  <= vals[i];
			@(posedge clk);
			while (!cfg_bus.ready)
				@(posedge clk);
			case (idx)
				ipwc_pkg::REG_HALF_RANGE:
					cfg_model.half_range = vals[i][ipwc_pkg::HR_W-1:0];
				ipwc_pkg::REG_SHORT:   cfg_model.nominal[0] = vals[i][ipwc_pkg::NOM_W-1:0];
				ipwc_pkg::REG_MIDDLE:  cfg_model.nominal[1] = vals[i][ipwc_pkg::NOM_W-1:0];
				ipwc_pkg::REG_LONG:    cfg_model.nominal[2] = vals[i][ipwc_pkg::NOM_W-1:0];
				ipwc_pkg::REG_QUALIFY: cfg_model.qualify    = vals[i][ipwc_pkg::QUAL_W-1:0];
				ipwc_pkg::REG_HOLD:    cfg_model.hold       = vals[i][ipwc_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
		cfg_bus.valid <= 1'b0;
	endtask

	// mostly well-formed pulses aimed at the windows, plus overflows, ticks and noise
	task automatic random_burst(input int n);
		int r, k, target, t;
		logic [ipwc_pkg::CH_W-1:0] ch;
		logic [ipwc_pkg::TIME_W-1:0] et;
		for (int i = 0; i < n; i++) begin
			r  = $urandom_range(0, 99);
			ch = ipwc_pkg::CH_W'($urandom_range(0, CHANNELS - 1));
			et = ipwc_pkg::TIME_W'($urandom);
			if (r < 6) begin
				send_word(ipwc_pkg::CMD_TICK, ch, et, 1'b0, '0);
			end else if (r < 8) begin
				send_word(CMD_UNKNOWN, ch, et, 1'b0, '0);
			end else if (r < 16) begin
				send_word(ipwc_pkg::CMD_OVF, ch, et, 1'b0, '0);
			end else begin
				if (armed_q[ch] && r < 85) begin
					// aim at a window, one tick past either edge at most
					k = $urandom_range(0, ipwc_pkg::NCLASS - 1);
					target = int'(cfg_model.nominal[k]) - int'(cfg_model.half_range) - 1
						+ $urandom_range(0, 2 * int'(cfg_model.half_range) + 2);
					t = target + int'(start_q[ch]) - (int'(ovf_cnt[ch]) << ipwc_pkg::TIME_W);
					if (t >= 0 && t < (1 << ipwc_pkg::TIME_W))
						et = ipwc_pkg::TIME_W'(t);
				end else if (!armed_q[ch] && r >= 70) begin
					// start late so the pulse spans an overflow
					et = ipwc_pkg::TIME_W'(65535 - $urandom_range(0, 3000));
				end
				send_word(ipwc_pkg::CMD_CAP, ch, et, 1'b0, '0);
			end
		end
	endtask

	// stop offering words and let every expected word arrive
	task automatic wait_drained();
		req_bus.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// response side: random ready gaps, one long hold-off on request
	initial begin
		int gap;
		ipwc_pkg::rsp_t want;
		rsp_bus.ready <= 1'b0;
		wait (arst_n);
		forever begin
			gap = $urandom_range(0, recv_idle_max);
			if (stall_req) begin
				gap = STALL_CYCLES;
				stall_req = 1'b0;
			end
			if (gap > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_bus.valid)
				@(posedge clk);
			if (expected_words.size() == 0) begin
				note_mismatch("word with nothing expected", '0, 32'(rsp_bus.presence_flags));
			end else begin
				want = expected_words.pop_front();
				if (rsp_bus.presence_flags !== want.presence_flags)
					note_mismatch("presence_flags", 32'(want.presence_flags),
						32'(rsp_bus.presence_flags));
				if (rsp_bus.width_valid !== want.width_valid)
					note_mismatch("width_valid", 32'(want.width_valid), 32'(rsp_bus.width_valid));
				if (rsp_bus.width_channel !== want.width_channel)
					note_mismatch("width_channel", 32'(want.width_channel),
						32'(rsp_bus.width_channel));
				if (rsp_bus.measured_width !== want.measured_width)
					note_mismatch("measured_width", 32'(want.measured_width),
						32'(rsp_bus.measured_width));
				if (rsp_bus.matched_class !== want.matched_class)
					note_mismatch("matched_class", 32'(want.matched_class),
						32'(rsp_bus.matched_class));
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
			|| (cfg_bus.valid && cfg_bus.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// main sequence
	initial begin
		arst_n            <= 1'b0;
		req_bus.valid     <= 1'b0;
		req_bus.cmd       <= ipwc_pkg::CMD_TICK;
		req_bus.channel   <= '0;
		req_bus.edge_time <= '0;
		cfg_bus.valid     <= 1'b0;
		cfg_bus.index     <= ipwc_pkg::REG_HALF_RANGE;
		cfg_bus.data      <= '0;

		cfg_model.half_range = ipwc_pkg::HALF_RANGE_RST;
		cfg_model.nominal[0] = ipwc_pkg::SHORT_RST;
		cfg_model.nominal[1] = ipwc_pkg::MIDDLE_RST;
		cfg_model.nominal[2] = ipwc_pkg::LONG_RST;
		cfg_model.qualify    = ipwc_pkg::QUALIFY_RST;
		cfg_model.hold       = ipwc_pkg::HOLD_RST;
		for (int c = 0; c < CHANNELS; c++) begin
			armed_q[c] = 1'b0;
			ovf_cnt[c] = '0;
			start_q[c] = '0;
			for (int k = 0; k < ipwc_pkg::NCLASS; k++) begin
				run_cnt[c][k]  = '0;
				flag_q[c][k]   = 1'b0;
				hold_cnt[c][k] = '0;
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset settings
		foreach (dir_rows[i])
			for (int r = 0; r < int'(dir_rows[i].reps); r++)
				send_word(dir_rows[i].cmd, dir_rows[i].channel, dir_rows[i].edge_time,
					dir_rows[i].typed && (r == int'(dir_rows[i].reps) - 1), dir_rows[i].want);
		wait_drained();

		// zero-width windows at the nominal extremes, single match qualifies
		write_settings(10'd0, 16'd0, 16'd65535, 16'd1500, 8'd1, 7'd0);
		random_burst(50);
		wait_drained();

		// wide windows overlap and reach below zero, longest hold
		send_idle_max = 0;
		write_settings(10'd1000, 16'd500, 16'd1000, 16'd1500, 8'd255, 7'd126);
		random_burst(50);
		wait_drained();

		// random settings
		send_idle_max = 16;
		recv_idle_max = 0;
		write_settings(ipwc_pkg::HR_W'($urandom_range(0, 300)),
			ipwc_pkg::NOM_W'($urandom_range(0, 1000)),
			ipwc_pkg::NOM_W'($urandom_range(1000, 3000)),
			ipwc_pkg::NOM_W'($urandom_range(2000, 6000)),
			ipwc_pkg::QUAL_W'($urandom_range(1, 4)),
			ipwc_pkg::HOLD_W'($urandom_range(0, 30)));
		random_burst(50);
		wait_drained();

		// back-to-back words with one long response hold-off
		send_idle_max = 0;
		write_settings(ipwc_pkg::HALF_RANGE_RST, ipwc_pkg::SHORT_RST, ipwc_pkg::MIDDLE_RST,
			ipwc_pkg::LONG_RST, 8'd2, 7'd5);
		random_burst(10);
		stall_req = 1'b1;
		random_burst(40);
		wait_drained();

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/ipwc_pkg.sv
hw/rtl/ipwc_if.sv
hw/rtl/ipwc_cfg.sv
hw/rtl/ipwc_lane.sv
hw/rtl/ir_pulse_width_classifier.sv
tb/ir_pulse_width_classifier_tb.sv
